// ===== hdl/lru_key_value_store_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the LRU key-value store.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_STORE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_STORE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// A condition that holds at every clock edge out of reset.
`define LRU_KVS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A condition that implies another in the same cycle.
`define LRU_KVS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define LRU_KVS_ASSERT(lbl, cond, msg)
`define LRU_KVS_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/lru_kvs_pkg.sv =====
// ---------------------------------------------------------------------------
// LRU key-value store package
// Item types, field widths and constants shared by the store modules.
// ---------------------------------------------------------------------------
package lru_kvs_pkg;

    localparam int KEY_BITS  = 31;
    localparam int DATA_BITS = 64;
    localparam int CAP_BITS  = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef enum logic
    {
        MODE_GET = 1'b0,
        MODE_PUT = 1'b1
    } mode_t;

    typedef struct packed
    {
        mode_t                mode;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] write_value;
    } req_t;

    typedef struct packed
    {
        logic                 hit;
        logic [DATA_BITS-1:0] read_value;
        logic                 evicted;
        logic [KEY_BITS-1:0]  evicted_key;
    } rsp_t;

    // Control from the pipeline to the entry store.
    typedef struct packed
    {
        logic step;
        logic clear;
    } store_ctrl_t;

endpackage

// ===== hdl/lru_kvs_store.sv =====
// ---------------------------------------------------------------------------
// LRU key-value store entries
// Holds keys, values, valid bits and recency ranks; matches one item
// against all entries and applies its update to the registered state.
// ---------------------------------------------------------------------------
`include "lru_key_value_store_top_defines.svh"

module lru_kvs_store #(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lru_kvs_pkg::store_ctrl_t             ctrl,
    input  logic [lru_kvs_pkg::CAP_BITS-1:0]     capacity,
    input  lru_kvs_pkg::req_t                    item,
    output lru_kvs_pkg::rsp_t                    result
);
    import lru_kvs_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    logic [KEY_BITS-1:0]   keys_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] values_reg [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;
    logic [RANK_W-1:0]     rank_reg   [ENTRIES];
    logic [RANK_W-1:0]     rank_next  [ENTRIES];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    victim;
    logic [ENTRIES-1:0]    free_slot;
    logic [ENTRIES-1:0]    slot;
    logic [RANK_W-1:0]     hit_rank;
    logic [RANK_W-1:0]     oldest_rank;
    logic [VALUE_BITS-1:0] hit_value;
    logic [KEY_BITS-1:0]   victim_key;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      eff_cap;
    logic                  hit;
    logic                  is_put;
    logic                  full;
    logic                  insert;
    logic                  evict;

    // Clamp the capacity register to 1..ENTRIES.
    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign full        = CMP_W'(count_reg) >= eff_cap;
    assign oldest_rank = RANK_W'(count_reg - 1'b1);
    // Lowest numbered empty entry.
    assign free_slot   = ~valid_reg & (valid_reg + 1'b1);

    // Keys are unique among valid entries, so the selections below are OR muxes.
    always_comb
    begin
        hit_rank   = '0;
        hit_value  = '0;
        victim_key = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]  = valid_reg[i] && (keys_reg[i] == item.key);
            // Ranks of valid entries are a permutation of 0..count-1.
            victim[i] = valid_reg[i] && (rank_reg[i] == oldest_rank);
            if (match[i])
            begin
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | values_reg[i];
            end
            if (victim[i])
            begin
                victim_key = victim_key | keys_reg[i];
            end
        end
    end

    assign hit    = |match;
    assign is_put = (item.mode == MODE_PUT);
    assign insert = is_put && !hit;
    assign evict  = insert && full;
    assign slot   = evict ? victim : free_slot;

    always_comb
    begin
        result.hit         = hit;
        result.read_value  = (hit && !is_put) ? DATA_BITS'(hit_value) : '0;
        result.evicted     = evict;
        result.evicted_key = evict ? victim_key : '0;
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (ctrl.clear)
        begin
            valid_next = '0;
            count_next = '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_next[i] = '0;
            end
        end
        else if (ctrl.step && hit)
        begin
            // Entries younger than the hit entry age by one.
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (match[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = RANK_W'(rank_reg[i] + 1'b1);
                end
            end
        end
        else if (ctrl.step && insert)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = RANK_W'(rank_reg[i] + 1'b1);
                end
            end
            valid_next = valid_reg | slot;
            if (!evict)
            begin
                count_next = CNT_W'(count_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step && !ctrl.clear)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if ((insert && slot[i]) || (is_put && match[i]))
                begin
                    values_reg[i] <= item.write_value[VALUE_BITS-1:0];
                end
                if (insert && slot[i])
                begin
                    keys_reg[i] <= item.key;
                end
            end
        end
    end

    `LRU_KVS_ASSERT(a_match_unique, $onehot0(match), "key matches several entries")
    `LRU_KVS_ASSERT(a_count_valid, $countones(valid_reg) == int'(count_reg), "bad entry count")
    `LRU_KVS_ASSERT_IMP(a_victim_single, evict, $onehot(victim), "no single oldest entry")
    `LRU_KVS_ASSERT_IMP(a_free_exists, insert && !full, $onehot(free_slot), "no empty entry")

endmodule

// ===== hdl/lru_key_value_store_top.sv =====
// ---------------------------------------------------------------------------
// LRU key-value store
// Fully associative key-value store with least-recently-used replacement.
//
//   Channel  Signals                        Direction  Content
//   req      req_valid, req_ready, req      in         mode, key, write_value
//   rsp      rsp_valid, rsp_ready, rsp      out        hit, read_value, evicted,
//                                                      evicted_key
//   cfg      cfg_write_en, cfg_write_data   in         capacity
//
// One item is taken every cycle while rsp_ready stays high; its result becomes valid
// when the result register captures the match on the input register.
// Match, victim choice and rank update are done against all entries at once.
// After reset the store is empty and capacity is 16; a capacity write empties it.
// When rsp_ready is low the result holds and one more item may wait in the
// input register before req_ready drops.
// ---------------------------------------------------------------------------
module lru_key_value_store_top #(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  lru_kvs_pkg::req_t                req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output lru_kvs_pkg::rsp_t                rsp,
    input  logic                             cfg_write_en,
    input  logic [lru_kvs_pkg::CAP_BITS-1:0] cfg_write_data
);
    import lru_kvs_pkg::*;

    logic                req_valid_reg;
    logic                req_valid_next;
    req_t                req_item_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_t                rsp_item_reg;
    rsp_t                store_result;
    logic [CAP_BITS-1:0] capacity_reg;
    logic                advance;
    logic                step;
    logic                take;
    store_ctrl_t         ctrl;

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign step      = req_valid_reg && advance;
    assign req_ready = !req_valid_reg || advance;
    assign take      = req_valid && req_ready;

    assign ctrl = '{step: step, clear: cfg_write_en};

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (take)
        begin
            req_valid_next = 1'b1;
        end
        else if (step)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (step)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            capacity_reg  <= CAP_RESET;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write_en)
            begin
                capacity_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_item_reg <= req;
        end
        if (step)
        begin
            rsp_item_reg <= store_result;
        end
    end

    lru_kvs_store #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .capacity (capacity_reg),
        .item     (req_item_reg),
        .result   (store_result)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_item_reg;

endmodule

// ===== tb/lru_key_value_store_top_tb.sv =====
// ---------------------------------------------------------------------------
// LRU key-value store testbench
// Sends get and put items through the request channel and checks every result
// against a cycle-free LRU predictor kept in the testbench. Capacity is changed
// between phases while the store is idle, and both channels idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module lru_key_value_store_top_tb;

    import lru_kvs_pkg::*;

    localparam int ENTRIES = 16;

    typedef struct
    {
        req_t        item;
        int unsigned lead;
    } pending_req_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                req_valid      = 1'b0;
    logic                req_ready;
    req_t                req            = '0;
    logic                rsp_valid;
    logic                rsp_ready      = 1'b0;
    rsp_t                rsp;
    logic                cfg_write_en   = 1'b0;
    logic [CAP_BITS-1:0] cfg_write_data = '0;

    pending_req_t pending_reqs[$];
    rsp_t         lru_expected[$];

    // Predicted contents of the store.
    logic [KEY_BITS-1:0]  lru_keys   [ENTRIES];
    logic [DATA_BITS-1:0] lru_values [ENTRIES];
    bit                   lru_valid  [ENTRIES];
    int unsigned          lru_rank   [ENTRIES];
    int unsigned          lru_count;
    logic [CAP_BITS-1:0]  cap_reg;

    int unsigned req_idle_max = 15;
    int unsigned rsp_idle_max = 15;
    int unsigned lead_count;
    int unsigned stall_count;
    int unsigned stall_draw;
    int unsigned error_count = 0;
    rsp_t        want_rsp;

    lru_key_value_store_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_store();
        for (int i = 0; i < ENTRIES; i++)
        begin
            lru_keys[i]   = '0;
            lru_values[i] = '0;
            lru_valid[i]  = 1'b0;
            lru_rank[i]   = 0;
        end
        lru_count = 0;
    endfunction

    // Applies one item to the predicted store and returns its result.
    function automatic rsp_t lru_access(input req_t r);
        rsp_t        res;
        int          found;
        int          slot;
        int unsigned best;
        int unsigned age;
        int unsigned limit;
        res   = '0;
        found = -1;
        slot  = -1;
        best  = 0;
        limit = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && lru_valid[i] && lru_keys[i] == r.key)
                found = i;
        if (found >= 0)
        begin
            res.hit = 1'b1;
            if (r.mode == MODE_GET)
                res.read_value = lru_values[found];
            else
                lru_values[found] = r.write_value;
            age = lru_rank[found];
            for (int i = 0; i < ENTRIES; i++)
                if (lru_valid[i] && i != found && lru_rank[i] < age)
                    lru_rank[i]++;
            lru_rank[found] = 0;
        end
        else if (r.mode == MODE_PUT)
        begin
            if (lru_count >= limit)
            begin
                // The oldest entry gives up its slot; ties go to the lowest index.
                for (int i = 0; i < ENTRIES; i++)
                    if (lru_valid[i] && (slot < 0 || lru_rank[i] > best))
                    begin
                        slot = i;
                        best = lru_rank[i];
                    end
                if (slot >= 0)
                begin
                    res.evicted     = 1'b1;
                    res.evicted_key = lru_keys[slot];
                    lru_valid[slot] = 1'b0;
                    lru_count--;
                end
            end
            if (slot < 0)
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !lru_valid[i])
                        slot = i;
            if (slot >= 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (lru_valid[i])
                        lru_rank[i]++;
                lru_keys[slot]   = r.key;
                lru_values[slot] = r.write_value;
                lru_valid[slot]  = 1'b1;
                lru_rank[slot]   = 0;
                lru_count++;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Request driver: each item waits out its own lead before valid rises.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req        <= '0;
            lead_count <= 0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_reqs.size() != 0 && lead_count >= pending_reqs[0].lead)
            begin
                req        <= pending_reqs[0].item;
                req_valid  <= 1'b1;
                lead_count <= 0;
                void'(pending_reqs.pop_front());
            end
            else
            begin
                req_valid <= 1'b0;
                if (pending_reqs.size() != 0)
                    lead_count <= lead_count + 1;
            end
        end
    end

    // Result monitor, result stalls and the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready   <= 1'b0;
            stall_count <= 0;
            clear_store();
            cap_reg = CAP_RESET;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (lru_expected.size() == 0)
                    report_mismatch("result with nothing expected",
                                    64'(rsp.evicted_key), '0);
                else
                begin
                    want_rsp = lru_expected.pop_front();
                    if (rsp.hit !== want_rsp.hit)
                        report_mismatch("hit", 64'(rsp.hit), 64'(want_rsp.hit));
                    if (rsp.read_value !== want_rsp.read_value)
                        report_mismatch("read_value", rsp.read_value, want_rsp.read_value);
                    if (rsp.evicted !== want_rsp.evicted)
                        report_mismatch("evicted", 64'(rsp.evicted),
                                        64'(want_rsp.evicted));
                    if (rsp.evicted_key !== want_rsp.evicted_key)
                        report_mismatch("evicted_key", 64'(rsp.evicted_key),
                                        64'(want_rsp.evicted_key));
                end
                stall_draw = $urandom_range(0, rsp_idle_max);
                stall_count <= stall_draw;
                rsp_ready   <= (stall_draw == 0);
            end
            else if (stall_count != 0)
            begin
                if (rsp_valid)
                begin
                    stall_count <= stall_count - 1;
                    rsp_ready   <= (stall_count == 1);
                end
            end
            else
                rsp_ready <= 1'b1;

            if (cfg_write_en)
            begin
                cap_reg = cfg_write_data;
                clear_store();
            end
            if (req_valid && req_ready)
                lru_expected.push_back(lru_access(req));
        end
    end

    task automatic queue_item(input mode_t mode, input logic [KEY_BITS-1:0] key,
                              input logic [DATA_BITS-1:0] value);
        pending_reqs.push_back('{item: '{mode: mode, key: key, write_value: value},
                                 lead: $urandom_range(0, req_idle_max)});
    endtask

    // Blocks until no item is queued, in flight or owed a result.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || lru_expected.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_write_data <= value;
        cfg_write_en   <= 1'b1;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    initial
    begin
        logic [CAP_BITS-1:0] phase_caps [10];
        logic [KEY_BITS-1:0] key_pool [$];
        logic [KEY_BITS-1:0] pick;
        int unsigned         usable;
        int unsigned         pool_size;

        phase_caps = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd2, 5'd17, 5'd5, 5'd12, 5'd3, 5'd0};
        phase_caps[9] = CAP_BITS'($urandom_range(0, 31));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset capacity: empty store, extreme keys and values.
        queue_item(MODE_GET, '0, '0);
        queue_item(MODE_PUT, '0, '1);
        queue_item(MODE_PUT, '1, '0);
        queue_item(MODE_GET, '0, 64'h0123_4567_89ab_cdef);
        queue_item(MODE_GET, '1, '1);
        queue_item(MODE_PUT, '0, 64'h0123_4567_89ab_cdef);
        queue_item(MODE_GET, '0, '0);
        queue_item(MODE_GET, 31'd5, '0);

        // Two entries: eviction of the oldest, with a hit refreshing its age.
        write_capacity(5'd2);
        queue_item(MODE_PUT, 31'd1, 64'h1111);
        queue_item(MODE_PUT, 31'd2, 64'h2222);
        queue_item(MODE_PUT, 31'd3, 64'h3333);
        queue_item(MODE_GET, 31'd1, '0);
        queue_item(MODE_GET, 31'd2, '0);
        queue_item(MODE_PUT, 31'd4, 64'h4444);
        queue_item(MODE_PUT, 31'd2, 64'h2020);
        queue_item(MODE_GET, 31'd4, '0);

        // A capacity of zero behaves as one.
        write_capacity(5'd0);
        queue_item(MODE_PUT, 31'd7, 64'h7777);
        queue_item(MODE_PUT, 31'd8, 64'h8888);
        queue_item(MODE_GET, 31'd8, '0);

        // Capacities above the entry count behave as the entry count.
        write_capacity(5'd31);
        queue_item(MODE_PUT, 31'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        queue_item(MODE_GET, 31'h5555_5555, '0);

        for (int phase = 0; phase < 10; phase++)
        begin
            write_capacity(phase_caps[phase]);
            req_idle_max = (phase % 3 == 0) ? 0 : 15;
            rsp_idle_max = (phase % 4 == 1) ? 0 : 15;
            usable = (phase_caps[phase] == 0) ? 1 :
                     ((phase_caps[phase] > ENTRIES) ? ENTRIES : phase_caps[phase]);
            // A pool a little larger than the capacity gives both hits and evictions.
            pool_size = usable + $urandom_range(0, usable + 2);
            key_pool.delete();
            for (int k = 0; k < pool_size; k++)
                key_pool.push_back(KEY_BITS'($urandom));
            for (int n = 0; n < 175; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    pick = KEY_BITS'($urandom);
                else
                    pick = key_pool[$urandom_range(0, pool_size - 1)];
                queue_item($urandom_range(0, 1) ? MODE_PUT : MODE_GET, pick,
                           {$urandom, $urandom});
            end
        end

        wait_idle();
        if (error_count == 0 && lru_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lru_kvs_pkg.sv
hdl/lru_kvs_store.sv
hdl/lru_key_value_store_top.sv
tb/lru_key_value_store_top_tb.sv
